### rtl/core/ptd_pkg.sv
package ptd_pkg;

  localparam int TASK_SLOTS_DEF  = 8;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int TICK_BITS       = 32;
  localparam int MAX_RESULTS     = 8;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
  localparam logic [1:0] ST_ZERO_PERIOD = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic do_add;
    logic do_delete;
    logic tick_inc;
    logic scan_first; // point at slot zero
    logic scan_next;  // advance to next slot
    logic div_start;
    logic fire;       // current slot due, keep it pending, clear if one-shot
  } ptd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       slot_live;  // current scan slot valid
    logic       scan_end;   // current slot is the last one
    logic       div_done;
    logic       div_zero;   // remainder zero
    logic       any_fired;  // a due slot is pending
    logic       res_full;   // max results reached
  } ptd_sts_t;

endpackage

### rtl/core/ptd_in_if.sv
interface ptd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  slot;
  logic [15:0] period;
  logic        one_shot;
  modport source (output valid, opcode, slot, period, one_shot, input ready);
  modport sink   (input valid, opcode, slot, period, one_shot, output ready);
endinterface

### rtl/core/ptd_out_if.sv
interface ptd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       fired;
  logic [2:0] fired_slot;
  logic       last;
  modport source (output valid, status, fired, fired_slot, last, input ready);
  modport sink   (input valid, status, fired, fired_slot, last, output ready);
endinterface

### rtl/core/ptd_divider.sv
module ptd_divider import ptd_pkg::*; #(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [TICK_BITS-1:0]   dividend,
  input  logic [PERIOD_BITS-1:0] divisor,
  output logic                   done,
  output logic                   rem_zero
);
  localparam int CNT_BITS = $clog2(TICK_BITS + 1);

  logic [TICK_BITS-1:0]   quo;
  logic [PERIOD_BITS:0]   rem;
  logic [PERIOD_BITS-1:0] dvs;
  logic [CNT_BITS-1:0]    cnt;
  logic                   busy;
  logic [PERIOD_BITS:0]   trial;
  logic [PERIOD_BITS:0]   diff;

  // one restoring step per cycle
  always_comb begin
    trial = {rem[PERIOD_BITS-1:0], quo[TICK_BITS-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(TICK_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[TICK_BITS-2:0], 1'b0};
      rem <= diff[PERIOD_BITS] ? trial : diff;
    end
  end

  assign rem_zero = (rem == '0);
endmodule

### rtl/core/ptd_datapath.sv
module ptd_datapath import ptd_pkg::*; #(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  ptd_cmd_t   cmd,
  output ptd_sts_t   sts,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_period,
  input  logic        in_one_shot,
  output logic [1:0]  add_status,
  output logic [1:0]  del_status,
  output logic [2:0]  cur_slot
);
  localparam int IDX_BITS = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_BITS = $clog2(TASK_SLOTS + 1);
  localparam int RES_BITS = $clog2(MAX_RESULTS + 1);

  logic [TASK_SLOTS-1:0]  valid;
  logic [PERIOD_BITS-1:0] per_mem [TASK_SLOTS];
  logic                   once_mem [TASK_SLOTS];
  logic [TICK_BITS-1:0]   tick;
  logic [CNT_BITS-1:0]    count;
  logic [RES_BITS-1:0]    nres;
  logic [1:0]             op_r;
  logic [2:0]             slot_r;
  logic [PERIOD_BITS-1:0] per_r;
  logic                   once_r;
  logic [IDX_BITS:0]      scan;
  logic [IDX_BITS-1:0]    sidx;
  logic [IDX_BITS-1:0]    aidx;
  logic [IDX_BITS-1:0]    pend_slot;
  logic                   slot_in;
  logic                   div_done;
  logic                   div_zero;

  assign aidx    = IDX_BITS'(slot_r);
  assign slot_in = ({29'd0, slot_r} < 32'(TASK_SLOTS));
  assign sidx    = scan[IDX_BITS-1:0];

  // add and delete outcome
  always_comb begin
    if (!slot_in) add_status = ST_NOT_FOUND;
    else if (!valid[aidx] && count >= CNT_BITS'(TASK_SLOTS)) add_status = ST_FULL;
    else if (per_r == '0) add_status = ST_ZERO_PERIOD;
    else add_status = ST_OK;
    del_status = (slot_in && valid[aidx]) ? ST_OK : ST_NOT_FOUND;
  end

  // control state of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      tick  <= '0;
      count <= '0;
      nres  <= '0;
      scan  <= '0;
    end else begin
      if (cmd.tick_inc) tick <= tick + 1'b1;
      if (cmd.scan_first) begin
        scan <= '0;
        nres <= '0;
      end else if (cmd.scan_next) begin
        scan <= scan + 1'b1;
      end
      if (cmd.do_add && add_status == ST_OK && !valid[aidx]) begin
        valid[aidx] <= 1'b1;
        count       <= count + 1'b1;
      end
      if (cmd.do_delete && del_status == ST_OK) begin
        valid[aidx] <= 1'b0;
        count       <= count - 1'b1;
      end
      if (cmd.fire) begin
        nres <= nres + 1'b1;
        if (once_mem[sidx]) begin
          valid[sidx] <= 1'b0;
          count       <= count - 1'b1;
        end
      end
    end
  end

  // payload capture, pending due slot and entry stores
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      slot_r <= in_slot;
      per_r  <= PERIOD_BITS'(in_period);
      once_r <= in_one_shot;
    end
    if (cmd.fire) pend_slot <= sidx;
    if (cmd.do_add && add_status == ST_OK) begin
      per_mem[aidx]  <= per_r;
      once_mem[aidx] <= once_r;
    end
  end

  ptd_divider #(.PERIOD_BITS(PERIOD_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tick),
    .divisor  (per_mem[sidx]),
    .done     (div_done),
    .rem_zero (div_zero)
  );

  assign cur_slot = 3'(pend_slot);

  always_comb begin
    sts.opcode    = op_r;
    sts.slot_live = valid[sidx];
    sts.scan_end  = (scan == (IDX_BITS+1)'(TASK_SLOTS - 1));
    sts.div_done  = div_done;
    sts.div_zero  = div_zero;
    sts.any_fired = (nres != '0);
    sts.res_full  = (nres == RES_BITS'(MAX_RESULTS));
  end
endmodule

### rtl/core/ptd_control.sv
module ptd_control import ptd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ptd_cmd_t cmd,
  input  ptd_sts_t sts,
  output logic     emit,       // load output register
  output logic     emit_fire,
  output logic     emit_last,
  output logic     emit_status_sel // 1 status from add/delete
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_NEXT = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0] state, state_next;
  logic       ovalid, ovalid_next;
  logic       ofree;

  assign ofree     = !ovalid || out_ready;
  assign out_valid = ovalid;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    ovalid_next     = ovalid && !out_ready;
    cmd             = '0;
    emit            = 1'b0;
    emit_fire       = 1'b0;
    emit_last       = 1'b0;
    emit_status_sel = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.opcode == OP_TICK) begin
          cmd.tick_inc   = 1'b1;
          cmd.scan_first = 1'b1;
          state_next     = S_TEST;
        end else if (ofree) begin
          cmd.do_add      = (sts.opcode == OP_ADD);
          cmd.do_delete   = (sts.opcode == OP_DELETE);
          emit            = 1'b1;
          emit_last       = 1'b1;
          emit_status_sel = 1'b1;
          ovalid_next     = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_TEST: begin
        if (sts.slot_live) begin
          cmd.div_start = 1'b1;
          state_next    = S_WAIT;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_WAIT: begin
        if (sts.div_done) begin
          if (sts.div_zero && sts.any_fired) begin
            state_next = S_HOLD;
          end else begin
            cmd.fire   = sts.div_zero;
            state_next = S_NEXT;
          end
        end
      end
      S_HOLD: begin
        // earlier due slot goes out, this one becomes pending
        if (ofree) begin
          cmd.fire    = 1'b1;
          emit        = 1'b1;
          emit_fire   = 1'b1;
          ovalid_next = 1'b1;
          state_next  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!sts.scan_end && !sts.res_full) begin
          cmd.scan_next = 1'b1;
          state_next    = S_TEST;
        end else if (ofree) begin
          // pending due slot or empty beat closes the tick
          emit        = 1'b1;
          emit_fire   = sts.any_fired;
          emit_last   = 1'b1;
          ovalid_next = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!ovalid || out_ready))
    else $error("beat loaded over an untaken beat");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE))
    else $error("input taken while busy");
  a_fire_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> sts.slot_live)
    else $error("fired slot not valid");
endmodule

### rtl/core/periodic_task_dispatcher_unit.sv
// add, delete, unused opcode load one result in the exec state once the output
// register is free; tick: a valid slot takes one 32-step serial remainder (and a
// hold state when it sends the previous due slot), an empty slot takes none
// a due slot goes out when the next due slot is found or the scan ends
// one item at a time; the next input is taken after the last result is loaded
// reset (rst, synchronous): table emptied, tick and task counts zero
module periodic_task_dispatcher_unit import ptd_pkg::*; #(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input logic  clk,
  input logic  rst,
  ptd_in_if.sink    in_ch,
  ptd_out_if.source out_ch
);
  ptd_cmd_t   cmd;
  ptd_sts_t   sts;
  logic       emit, emit_fire, emit_last, emit_status_sel;
  logic [1:0] add_status, del_status;
  logic [2:0] cur_slot;

  ptd_control u_ctl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .cmd             (cmd),
    .sts             (sts),
    .emit            (emit),
    .emit_fire       (emit_fire),
    .emit_last       (emit_last),
    .emit_status_sel (emit_status_sel)
  );

  ptd_datapath #(.TASK_SLOTS(TASK_SLOTS), .PERIOD_BITS(PERIOD_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_opcode   (in_ch.opcode),
    .in_slot     (in_ch.slot),
    .in_period   (in_ch.period),
    .in_one_shot (in_ch.one_shot),
    .add_status  (add_status),
    .del_status  (del_status),
    .cur_slot    (cur_slot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.fired      <= emit_fire;
      out_ch.fired_slot <= emit_fire ? cur_slot : 3'd0;
      out_ch.last       <= emit_last;
      if (emit_status_sel && sts.opcode == OP_ADD) out_ch.status <= add_status;
      else if (emit_status_sel && sts.opcode == OP_DELETE) out_ch.status <= del_status;
      else out_ch.status <= ST_OK;
    end
  end
endmodule
